FILE: design/integer_to_ascii_formatter_defines.svh
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define I2A_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2a check failed");

// next-cycle implication, sampled on aclk, off during reset
`define I2A_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2a check failed");

`endif

FILE: design/i2a_pkg.sv
package i2a_pkg;

    localparam int VALUE_W        = 64;
    localparam int CNT_W          = 7;
    localparam int BITS_PER_STEP  = 4;
    localparam int STEPS          = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(STEPS);
    localparam int MAX_DIGITS_DEF = 20;
    localparam int MAX_OUT_DEF    = 64;

    localparam logic [1:0] MODE_DEC   = 2'd0;
    localparam logic [1:0] MODE_LOWER = 2'd1;
    localparam logic [1:0] MODE_UPPER = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [7:0] LOWER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] UPPER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [7:0]       pad_char;
        logic [CNT_W-1:0] npad;
        logic [CNT_W-1:0] ndig;
        logic [CNT_W-1:0] nfull;
        logic             hex;
        logic             upper;
    } fmt_ctl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic hex,
                                              input logic upper);
        logic [7:0] c;
        if (!hex) begin
            c = ASCII_ZERO + {4'b0000, d};
        end else if (upper) begin
            c = UPPER_DIGITS[d];
        end else begin
            c = LOWER_DIGITS[d];
        end
        return c;
    endfunction

endpackage

FILE: design/integer_to_ascii_formatter.sv
// Front: hex values skip conversion; decimal runs sixteen 4-bit double-dabble steps.
// Back: takes an item, then one character per cycle while m_tready is held high.
// A two-entry queue lets the front convert the next item while the back emits.
// Reset: aresetn synchronous, active low; clears control state, no clearing pass.
module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int MAX_OUT    = MAX_OUT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // value[63:0], pad_char[71:64], min_width[78:72],
                                  // space_left[85:79], zero[87:86]
    input  logic [1:0]  s_tuser,  // radix_mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // out_char[7:0]
    output logic        m_tlast
);

    localparam int DIG_W = 4 * MAX_DIGITS;
    localparam int Q_W   = $bits(fmt_ctl_t) + DIG_W;

    logic             q_push, q_full, q_pop, q_valid;
    fmt_ctl_t         f_ctl, b_ctl;
    logic [DIG_W-1:0] f_digits, b_digits;
    logic [Q_W-1:0]   q_head;

    assign b_ctl    = q_head[Q_W-1 -: $bits(fmt_ctl_t)];
    assign b_digits = q_head[DIG_W-1:0];

    i2a_front #(
        .MAX_DIGITS(MAX_DIGITS),
        .MAX_OUT   (MAX_OUT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .value     (s_tdata[63:0]),
        .radix_mode(s_tuser),
        .pad_char  (s_tdata[71:64]),
        .min_width (s_tdata[78:72]),
        .space_left(s_tdata[85:79]),
        .q_push    (q_push),
        .q_ctl     (f_ctl),
        .q_digits  (f_digits),
        .q_full    (q_full)
    );

    i2a_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({f_ctl, f_digits}),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    i2a_back #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ctl   (b_ctl),
        .q_digits(b_digits),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

FILE: design/i2a_queue.sv
module i2a_queue
    import i2a_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] head
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/i2a_front.sv
module i2a_front
    import i2a_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int MAX_OUT    = MAX_OUT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [VALUE_W-1:0]      value,
    input  logic [1:0]              radix_mode,
    input  logic [7:0]              pad_char,
    input  logic [CNT_W-1:0]        min_width,
    input  logic [CNT_W-1:0]        space_left,
    output logic                    q_push,
    output fmt_ctl_t                q_ctl,
    output logic [4*MAX_DIGITS-1:0] q_digits,
    input  logic                    q_full
);

    localparam int DIG_W = 4 * MAX_DIGITS;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_DONE = 3'b100
    } fstate_t;

    fstate_t            state_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [DIG_W-1:0]   bcd_reg, bcd_next;
    logic               ovf_reg, ovf_next;
    logic [STEP_W-1:0]  step_reg;
    logic               hex_reg, upper_reg;
    logic [7:0]         pad_reg;
    logic [CNT_W-1:0]   width_reg, space_reg;
    logic [CNT_W-1:0]   nfull, npad, ndig;
    logic               accept, hex_in;

    assign in_ready = (state_reg == F_IDLE);
    assign accept   = in_valid && in_ready;
    assign hex_in   = (radix_mode == MODE_LOWER) || (radix_mode == MODE_UPPER);

    // four shift-add-3 steps per cycle, top bits of the value first
    always_comb begin
        bcd_next = bcd_reg;
        ovf_next = ovf_reg;
        for (int j = 0; j < BITS_PER_STEP; j++) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (bcd_next[4*i +: 4] >= 4'd5) begin
                    bcd_next[4*i +: 4] = bcd_next[4*i +: 4] + 4'd3;
                end
            end
            ovf_next = ovf_next | bcd_next[DIG_W-1];
            bcd_next = {bcd_next[DIG_W-2:0], val_reg[VALUE_W-1-j]};
        end
    end

    always_comb begin
        nfull = CNT_W'(1);
        for (int i = 1; i < MAX_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                nfull = CNT_W'(i + 1);
            end
        end
        if (ovf_reg) begin
            nfull = CNT_W'(MAX_DIGITS);
        end
        npad = '0;
        if (width_reg > nfull) begin
            npad = width_reg - nfull;
            if (npad > space_reg) begin
                npad = space_reg;
            end
        end
        ndig = nfull;
        if (ndig > space_reg - npad) begin
            ndig = space_reg - npad;
        end
    end

    assign q_push         = (state_reg == F_DONE) && (space_reg != '0) && !q_full;
    assign q_digits       = bcd_reg;
    assign q_ctl.pad_char = pad_reg;
    assign q_ctl.npad     = npad;
    assign q_ctl.ndig     = ndig;
    assign q_ctl.nfull    = nfull;
    assign q_ctl.hex      = hex_reg;
    assign q_ctl.upper    = upper_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        state_reg <= hex_in ? F_DONE : F_CONV;
                    end
                end
                F_CONV: begin
                    if (step_reg == STEP_W'(STEPS - 1)) begin
                        state_reg <= F_DONE;
                    end
                end
                F_DONE: begin
                    if ((space_reg == '0) || !q_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            val_reg   <= value;
            hex_reg   <= hex_in;
            upper_reg <= (radix_mode == MODE_UPPER);
            pad_reg   <= pad_char;
            width_reg <= min_width;
            space_reg <= (space_left > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : space_left;
            bcd_reg   <= hex_in ? DIG_W'(value) : '0;
            ovf_reg   <= 1'b0;
            step_reg  <= '0;
        end else if (state_reg == F_CONV) begin
            val_reg  <= val_reg << BITS_PER_STEP;
            bcd_reg  <= bcd_next;
            ovf_reg  <= ovf_next;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

endmodule

FILE: design/i2a_back.sv
`include "integer_to_ascii_formatter_defines.svh"

module i2a_back
    import i2a_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    input  fmt_ctl_t                q_ctl,
    input  logic [4*MAX_DIGITS-1:0] q_digits,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast
);

    localparam int IDX_W = $clog2(MAX_DIGITS);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_PAD  = 3'b010,
        B_DIG  = 3'b100
    } bstate_t;

    bstate_t                 state_reg;
    logic [CNT_W-1:0]        pad_cnt_reg, dig_cnt_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [4*MAX_DIGITS-1:0] digits_reg;
    logic [7:0]              pad_char_reg;
    logic                    hex_reg, upper_reg;
    logic                    m_tvalid_reg;
    logic [7:0]              m_tdata_reg;
    logic                    m_tlast_reg;
    logic                    emit, last;
    logic [7:0]              char_next;
    logic [CNT_W-1:0]        idx_full;

    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign emit     = (state_reg != B_IDLE) && (!m_tvalid_reg || m_tready);
    assign last     = ((state_reg == B_PAD) && (pad_cnt_reg == CNT_W'(1))
                       && (dig_cnt_reg == '0))
                   || ((state_reg == B_DIG) && (dig_cnt_reg == CNT_W'(1)));
    assign char_next = (state_reg == B_PAD) ? pad_char_reg
                     : digit_char(digits_reg[4*idx_reg +: 4], hex_reg, upper_reg);
    assign idx_full  = q_ctl.nfull - CNT_W'(1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_pop) begin
                        state_reg <= (q_ctl.npad != '0) ? B_PAD : B_DIG;
                    end
                end
                B_PAD: begin
                    if (emit && (pad_cnt_reg == CNT_W'(1))) begin
                        state_reg <= (dig_cnt_reg == '0) ? B_IDLE : B_DIG;
                    end
                end
                B_DIG: begin
                    if (emit && (dig_cnt_reg == CNT_W'(1))) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pad_cnt_reg  <= q_ctl.npad;
            dig_cnt_reg  <= q_ctl.ndig;
            idx_reg      <= idx_full[IDX_W-1:0];
            digits_reg   <= q_digits;
            pad_char_reg <= q_ctl.pad_char;
            hex_reg      <= q_ctl.hex;
            upper_reg    <= q_ctl.upper;
        end else if (emit) begin
            if (state_reg == B_PAD) begin
                pad_cnt_reg <= pad_cnt_reg - CNT_W'(1);
            end else begin
                dig_cnt_reg <= dig_cnt_reg - CNT_W'(1);
                idx_reg     <= idx_reg - IDX_W'(1);
            end
        end
        if (emit) begin
            m_tdata_reg <= char_next;
            m_tlast_reg <= last;
        end
    end

    `I2A_ASSERT_IMP(a_pad_nonzero, state_reg == B_PAD, pad_cnt_reg != '0)
    `I2A_ASSERT_IMP(a_dig_nonzero, state_reg == B_DIG, dig_cnt_reg != '0)
    `I2A_ASSERT_NXT(a_last_ends, emit && last, state_reg == B_IDLE && m_tlast_reg)

endmodule
